// ----- rtl/core/json_string_unescape_utf8_defines.svh -----
// Assertion helpers; expect clk and rst_n in scope.
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// Same-cycle implication.
`define JSU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define JSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/core/jsu_pkg.sv -----
`default_nettype none

package jsu_pkg;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ERR_EXPECTED_STRING   = 4'd0,
    ERR_CONTROL_CHAR      = 4'd1,
    ERR_UNTERM_ESCAPE     = 4'd2,
    ERR_BAD_ESCAPE        = 4'd3,
    ERR_INCOMPLETE_UNI    = 4'd4,
    ERR_BAD_HEX           = 4'd5,
    ERR_MISSING_LOW       = 4'd6,
    ERR_INVALID_LOW       = 4'd7,
    ERR_UNEXPECTED_LOW    = 4'd8,
    ERR_UNTERMINATED      = 4'd9
  } err_code_t;

  // One queued result: a code point to encode, a raw byte, a completion or an error.
  typedef struct packed {
    kind_t       kind;
    err_code_t   err;
    logic        single;  // emit cp[7:0] as is, no UTF-8 expansion
    logic [20:0] cp;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/jsu_front.sv -----
`default_nettype none

module jsu_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [7:0]      in_tdata,
  input  wire logic            in_tlast,
  input  wire jsu_pkg::q_status_t q_st,
  output logic                 push,
  output jsu_pkg::entry_t      push_entry
);
  import jsu_pkg::*;

  typedef enum logic [3:0] {
    PH_WAIT, PH_BODY, PH_ESC, PH_HEX1, PH_BSL, PH_U, PH_HEX2, PH_DONE, PH_ERR
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [9:0]  hs_r, hs_nxt;
  logic        accept;
  logic        fault;
  err_code_t   fault_code;
  logic [4:0]  hx;
  logic [15:0] word;

  // {valid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  assign in_tready = !q_st.full;
  assign accept    = in_tvalid && in_tready;
  assign hx        = hex_decode(in_tdata);
  assign word      = {acc_r, hx[3:0]};

  always_comb begin
    phase_nxt         = phase_r;
    acc_nxt           = acc_r;
    cnt_nxt           = cnt_r;
    hs_nxt            = hs_r;
    fault             = 1'b0;
    fault_code        = ERR_EXPECTED_STRING;
    push              = 1'b0;
    push_entry.kind   = KIND_DATA;
    push_entry.err    = ERR_EXPECTED_STRING;
    push_entry.single = 1'b1;
    push_entry.cp     = {13'd0, in_tdata};
    if (accept) begin
      if (in_tlast) begin
        phase_nxt = PH_WAIT;
        acc_nxt   = '0;
        cnt_nxt   = '0;
        hs_nxt    = '0;
        case (phase_r)
          PH_WAIT: begin
            fault = 1'b1; fault_code = ERR_EXPECTED_STRING;
          end
          PH_BODY: begin
            fault = 1'b1; fault_code = ERR_UNTERMINATED;
          end
          PH_ESC: begin
            fault = 1'b1; fault_code = ERR_UNTERM_ESCAPE;
          end
          PH_HEX1, PH_HEX2: begin
            fault = 1'b1; fault_code = ERR_INCOMPLETE_UNI;
          end
          PH_BSL, PH_U: begin
            fault = 1'b1; fault_code = ERR_MISSING_LOW;
          end
          default: begin
          end
        endcase
      end else begin
        case (phase_r)
          PH_WAIT: begin
            if (in_tdata inside {8'h20, [8'h09:8'h0D]}) begin
            end else if (in_tdata == 8'h22) begin
              phase_nxt = PH_BODY;
            end else begin
              fault = 1'b1; fault_code = ERR_EXPECTED_STRING;
            end
          end
          PH_BODY: begin
            if (in_tdata == 8'h22) begin
              phase_nxt       = PH_DONE;
              push            = 1'b1;
              push_entry.kind = KIND_DONE;
              push_entry.cp   = '0;
            end else if (in_tdata < 8'h20) begin
              fault = 1'b1; fault_code = ERR_CONTROL_CHAR;
            end else if (in_tdata == 8'h5C) begin
              phase_nxt = PH_ESC;
            end else begin
              push = 1'b1;
            end
          end
          PH_ESC: begin
            phase_nxt = PH_BODY;
            case (in_tdata)
              8'h22, 8'h5C, 8'h2F: push = 1'b1;
              8'h62: begin push = 1'b1; push_entry.cp = 21'h08; end
              8'h66: begin push = 1'b1; push_entry.cp = 21'h0C; end
              8'h6E: begin push = 1'b1; push_entry.cp = 21'h0A; end
              8'h72: begin push = 1'b1; push_entry.cp = 21'h0D; end
              8'h74: begin push = 1'b1; push_entry.cp = 21'h09; end
              8'h75: begin
                phase_nxt = PH_HEX1;
                acc_nxt   = '0;
                cnt_nxt   = '0;
              end
              default: begin
                fault = 1'b1; fault_code = ERR_BAD_ESCAPE;
              end
            endcase
          end
          PH_HEX1, PH_HEX2: begin
            if (!hx[4]) begin
              fault = 1'b1; fault_code = ERR_BAD_HEX;
            end else if (cnt_r != 2'd3) begin
              acc_nxt = word[11:0];
              cnt_nxt = cnt_r + 2'd1;
            end else begin
              acc_nxt = '0;
              cnt_nxt = '0;
              if (phase_r == PH_HEX1) begin
                if (word[15:10] == 6'b110110) begin
                  hs_nxt    = word[9:0];
                  phase_nxt = PH_BSL;
                end else if (word[15:10] == 6'b110111) begin
                  fault = 1'b1; fault_code = ERR_UNEXPECTED_LOW;
                end else begin
                  phase_nxt         = PH_BODY;
                  push              = 1'b1;
                  push_entry.single = 1'b0;
                  push_entry.cp     = {5'd0, word};
                end
              end else begin
                if (word[15:10] != 6'b110111) begin
                  fault = 1'b1; fault_code = ERR_INVALID_LOW;
                end else begin
                  phase_nxt         = PH_BODY;
                  push              = 1'b1;
                  push_entry.single = 1'b0;
                  push_entry.cp     = {({1'b0, hs_r} + 11'd64), word[9:0]};
                end
              end
            end
          end
          PH_BSL: begin
            if (in_tdata != 8'h5C) begin
              fault = 1'b1; fault_code = ERR_MISSING_LOW;
            end else begin
              phase_nxt = PH_U;
            end
          end
          PH_U: begin
            if (in_tdata != 8'h75) begin
              fault = 1'b1; fault_code = ERR_MISSING_LOW;
            end else begin
              phase_nxt = PH_HEX2;
              acc_nxt   = '0;
              cnt_nxt   = '0;
            end
          end
          default: begin
          end
        endcase
      end
      if (fault) begin
        push              = 1'b1;
        push_entry.kind   = KIND_ERROR;
        push_entry.err    = fault_code;
        push_entry.single = 1'b1;
        push_entry.cp     = '0;
        if (!in_tlast) begin
          phase_nxt = PH_ERR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      acc_r   <= '0;
      cnt_r   <= '0;
      hs_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      hs_r    <= hs_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/jsu_queue.sv -----
`default_nettype none
`include "json_string_unescape_utf8_defines.svh"

module jsu_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire jsu_pkg::entry_t push_entry,
  input  wire logic            pop,
  output jsu_pkg::entry_t      head,
  output jsu_pkg::q_status_t   q_st
);
  import jsu_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign q_st.full  = (count_r == CW'(DEPTH));
  assign q_st.empty = (count_r == '0);
  assign do_push    = push && !q_st.full;
  assign do_pop     = pop && !q_st.empty;
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  `JSU_ASSERT_NOW(a_no_push_full, push, !q_st.full)
  `JSU_ASSERT_NOW(a_no_pop_empty, pop, !q_st.empty)
  `JSU_ASSERT_NEXT(a_push_fills, do_push && !do_pop, !q_st.empty)

endmodule

`default_nettype wire

// ----- rtl/core/jsu_back.sv -----
`default_nettype none
`include "json_string_unescape_utf8_defines.svh"

module jsu_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire jsu_pkg::q_status_t q_st,
  input  wire jsu_pkg::entry_t    head,
  output logic                    pop,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [15:0]             out_tdata,
  output logic [1:0]              out_tuser,
  output logic                    out_tlast
);
  import jsu_pkg::*;

  logic       valid_r;
  logic [1:0] idx_r;
  logic [7:0] byte_r;
  kind_t      kind_r;
  err_code_t  err_r;
  logic       last_r;
  logic [1:0] last_idx;
  logic       load;
  logic       at_last;
  logic [7:0] cur_byte;

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] n,
                                           input logic [1:0] i);
    logic [7:0] b;
    b = cp[7:0];
    case (n)
      2'd1: b = (i == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      2'd2: begin
        case (i)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      2'd3: begin
        case (i)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: b = cp[7:0];
    endcase
    return b;
  endfunction

  always_comb begin
    if (head.single || head.cp <= 21'h7F) begin
      last_idx = 2'd0;
    end else if (head.cp <= 21'h7FF) begin
      last_idx = 2'd1;
    end else if (head.cp <= 21'hFFFF) begin
      last_idx = 2'd2;
    end else begin
      last_idx = 2'd3;
    end
  end

  assign load     = !q_st.empty && (!valid_r || out_tready);
  assign at_last  = (idx_r == last_idx);
  assign pop      = load && at_last;
  assign cur_byte = utf8_byte(head.cp, last_idx, idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= at_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= cur_byte;
      kind_r <= head.kind;
      err_r  <= head.err;
      last_r <= at_last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {4'd0, err_r, byte_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

  `JSU_ASSERT_NOW(a_mid_seq_has_head, idx_r != 2'd0, !q_st.empty)
  `JSU_ASSERT_NOW(a_mid_seq_is_cp, idx_r != 2'd0, head.kind == KIND_DATA && !head.single)

endmodule

`default_nettype wire

// ----- rtl/core/json_string_unescape_utf8.sv -----
// JSON string unescaper with UTF-8 output.
// Input: one source byte per transaction on in_tdata; in_tlast marks end of
// source (byte ignored) and returns the parser to the start state.
// Output: one result per transaction; out_tuser is the kind (data, string
// complete, error), out_tdata carries the byte and error code, out_tlast
// marks the final result caused by one input transaction.
// The parser front end takes one byte per cycle while the queue has room
// and writes at most one entry (code point, raw byte, completion or error)
// per byte into a QUEUE_DEPTH entry queue; the encoder back end drains one
// output byte per cycle while the receiver accepts; a code point yields 1 to 4
// output bytes. A result passes a queue entry, then the output register.
// Throughput: 1 input byte per cycle while the queue has room; in_tready
// drops only when the queue is full.
// Reset clears parser state, queue and output valid; no clearing pass.
// When the receiver stalls, the output holds and the queue fills, then
// the input stalls.
`default_nettype none

module json_string_unescape_utf8 #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,   // end_of_input
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] out_byte, [11:8] error_code, [15:12] zero
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast   // last_of_run
);
  import jsu_pkg::*;

  q_status_t q_st;
  logic      push;
  entry_t    push_entry;
  logic      pop;
  entry_t    head;

  jsu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .q_st       (q_st),
    .push       (push),
    .push_entry (push_entry)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_st       (q_st)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_st       (q_st),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ----- dv/jsu_checker.sv -----
`timescale 1ns / 1ps

module jsu_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic        in_tlast,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata,
  input  wire logic [1:0]  out_tuser,
  input  wire logic        out_tlast,
  output int               fail_count,
  output int               pending_count
);
  import jsu_pkg::*;

  localparam logic [7:0] QUOTE    = 8'h22;
  localparam logic [7:0] BSLASH   = 8'h5C;
  localparam logic [7:0] LETTER_U = 8'h75;
  localparam logic [7:0] SPACE    = 8'h20;

  typedef enum logic [3:0] {
    ST_SEEK_QUOTE,
    ST_BODY,
    ST_ESCAPE,
    ST_HEX_FIRST,
    ST_WANT_BSL,
    ST_WANT_U,
    ST_HEX_LOW,
    ST_DONE,
    ST_FAILED
  } parse_state_t;

  typedef struct {
    logic [7:0] data;
    kind_t      kind;
    err_code_t  code;
    logic       last;
  } result_t;

  parse_state_t state;
  logic [15:0]  hex_acc;
  logic [1:0]   hex_cnt;
  logic [9:0]   high_bits;
  result_t      step_results[$];
  result_t      decoded_results[$];

  task automatic clear_state();
    state     = ST_SEEK_QUOTE;
    hex_acc   = '0;
    hex_cnt   = '0;
    high_bits = '0;
  endtask

  // code is zero (ERR_EXPECTED_STRING) for data and completion
  task automatic add_result(input logic [7:0] b, input kind_t k, input err_code_t e);
    result_t r;
    r.data = b;
    r.kind = k;
    r.code = e;
    r.last = 1'b0;
    step_results.insert(step_results.size(), r);
  endtask

  task automatic fail_with(input err_code_t e);
    state = ST_FAILED;
    add_result(8'h00, KIND_ERROR, e);
  endtask

  task automatic emit_utf8(input int cp);
    if (cp <= 'h7F) begin
      add_result(8'(cp), KIND_DATA, ERR_EXPECTED_STRING);
    end else if (cp <= 'h7FF) begin
      add_result(8'('hC0 | (cp >> 6)), KIND_DATA, ERR_EXPECTED_STRING);
      add_result(8'('h80 | (cp & 'h3F)), KIND_DATA, ERR_EXPECTED_STRING);
    end else if (cp <= 'hFFFF) begin
      add_result(8'('hE0 | (cp >> 12)), KIND_DATA, ERR_EXPECTED_STRING);
      add_result(8'('h80 | ((cp >> 6) & 'h3F)), KIND_DATA, ERR_EXPECTED_STRING);
      add_result(8'('h80 | (cp & 'h3F)), KIND_DATA, ERR_EXPECTED_STRING);
    end else begin
      add_result(8'('hF0 | ((cp >> 18) & 'h07)), KIND_DATA, ERR_EXPECTED_STRING);
      add_result(8'('h80 | ((cp >> 12) & 'h3F)), KIND_DATA, ERR_EXPECTED_STRING);
      add_result(8'('h80 | ((cp >> 6) & 'h3F)), KIND_DATA, ERR_EXPECTED_STRING);
      add_result(8'('h80 | (cp & 'h3F)), KIND_DATA, ERR_EXPECTED_STRING);
    end
  endtask

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
    if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
    return -1;
  endfunction

  task automatic unescape_predict(input logic [7:0] c, input logic eoi);
    int d;
    int v;
    result_t r;
    step_results.delete();
    if (eoi) begin
      case (state)
        ST_SEEK_QUOTE:          add_result(8'h00, KIND_ERROR, ERR_EXPECTED_STRING);
        ST_BODY:                add_result(8'h00, KIND_ERROR, ERR_UNTERMINATED);
        ST_ESCAPE:              add_result(8'h00, KIND_ERROR, ERR_UNTERM_ESCAPE);
        ST_HEX_FIRST, ST_HEX_LOW: add_result(8'h00, KIND_ERROR, ERR_INCOMPLETE_UNI);
        ST_WANT_BSL, ST_WANT_U: add_result(8'h00, KIND_ERROR, ERR_MISSING_LOW);
        default: ;
      endcase
      clear_state();
    end else begin
      case (state)
        ST_SEEK_QUOTE: begin
          if (c == QUOTE) state = ST_BODY;
          else if (!(c == SPACE || (c >= 8'h09 && c <= 8'h0D))) fail_with(ERR_EXPECTED_STRING);
        end
        ST_BODY: begin
          if (c == QUOTE) begin
            state = ST_DONE;
            add_result(8'h00, KIND_DONE, ERR_EXPECTED_STRING);
          end else if (c < SPACE) begin
            fail_with(ERR_CONTROL_CHAR);
          end else if (c == BSLASH) begin
            state = ST_ESCAPE;
          end else begin
            add_result(c, KIND_DATA, ERR_EXPECTED_STRING);
          end
        end
        ST_ESCAPE: begin
          state = ST_BODY;
          case (c)
            QUOTE, BSLASH, 8'h2F: add_result(c, KIND_DATA, ERR_EXPECTED_STRING);
            8'h62: add_result(8'h08, KIND_DATA, ERR_EXPECTED_STRING);
            8'h66: add_result(8'h0C, KIND_DATA, ERR_EXPECTED_STRING);
            8'h6E: add_result(8'h0A, KIND_DATA, ERR_EXPECTED_STRING);
            8'h72: add_result(8'h0D, KIND_DATA, ERR_EXPECTED_STRING);
            8'h74: add_result(8'h09, KIND_DATA, ERR_EXPECTED_STRING);
            LETTER_U: begin
              state   = ST_HEX_FIRST;
              hex_acc = '0;
              hex_cnt = '0;
            end
            default: fail_with(ERR_BAD_ESCAPE);
          endcase
        end
        ST_HEX_FIRST, ST_HEX_LOW: begin
          d = nibble_of(c);
          if (d < 0) begin
            fail_with(ERR_BAD_HEX);
          end else begin
            hex_acc = {hex_acc[11:0], d[3:0]};
            if (hex_cnt != 2'd3) begin
              hex_cnt++;
            end else begin
              hex_cnt = '0;
              v       = hex_acc;
              hex_acc = '0;
              if (state == ST_HEX_FIRST) begin
                if (v >= 'hD800 && v <= 'hDBFF) begin
                  high_bits = 10'(v - 'hD800);
                  state     = ST_WANT_BSL;
                end else if (v >= 'hDC00 && v <= 'hDFFF) begin
                  fail_with(ERR_UNEXPECTED_LOW);
                end else begin
                  state = ST_BODY;
                  emit_utf8(v);
                end
              end else if (v < 'hDC00 || v > 'hDFFF) begin
                fail_with(ERR_INVALID_LOW);
              end else begin
                state = ST_BODY;
                emit_utf8('h10000 + {high_bits, 10'd0} + (v - 'hDC00));
              end
            end
          end
        end
        ST_WANT_BSL: begin
          if (c != BSLASH) fail_with(ERR_MISSING_LOW);
          else state = ST_WANT_U;
        end
        ST_WANT_U: begin
          if (c != LETTER_U) begin
            fail_with(ERR_MISSING_LOW);
          end else begin
            state   = ST_HEX_LOW;
            hex_acc = '0;
            hex_cnt = '0;
          end
        end
        default: ;
      endcase
    end
    foreach (step_results[i]) begin
      r      = step_results[i];
      r.last = (i == step_results.size() - 1);
      decoded_results.insert(decoded_results.size(), r);
    end
  endtask

  task automatic cmp_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic check_result();
    result_t r;
    if (decoded_results.size() == 0) begin
      $error("unexpected transaction: out_tdata %04h out_tuser %0d", out_tdata, out_tuser);
      fail_count++;
    end else begin
      r = decoded_results.pop_front();
      cmp_field("out_byte", r.data, out_tdata[7:0]);
      cmp_field("error_code", r.code, out_tdata[11:8]);
      cmp_field("tdata_pad", 8'h00, out_tdata[15:12]);
      cmp_field("kind", r.kind, out_tuser);
      cmp_field("last_of_run", r.last, out_tlast);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      decoded_results.delete();
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready) unescape_predict(in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_result();
    end
    pending_count = decoded_results.size();
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET    = 450;

  localparam logic [7:0] QUOTE    = 8'h22;
  localparam logic [7:0] BSLASH   = 8'h5C;
  localparam logic [7:0] LETTER_U = 8'h75;

  localparam logic [47:0] WS_CHARS  = {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  localparam logic [63:0] ESC_CHARS = {8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};
  localparam logic [95:0] BMP_EDGES = {16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};

  typedef enum int {
    FLT_CTRL,
    FLT_BAD_ESC,
    FLT_BAD_HEX,
    FLT_LONE_LOW,
    FLT_NO_BSL,
    FLT_NO_U,
    FLT_BAD_LOW,
    FLT_LOW_HEX
  } fault_t;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PULSE
  } rx_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tready = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [15:0] out_tdata;
  wire  [1:0]  out_tuser;
  wire         out_tlast;

  int          fail_count;
  int          pending_count;
  logic [8:0]  src_q[$];  // {end_of_input, byte}
  int          burst_left  = 0;
  int          sent_items  = 0;
  int          idle_cycles = 0;
  rx_mode_t    rx_mode     = RX_OPEN;
  int          rx_left     = 0;
  int          rx_tick     = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  json_string_unescape_utf8 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  jsu_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 128);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
      default:   out_tready <= rx_tick[2];
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return 8'h30 + n;
    return 8'((($urandom_range(0, 1) == 1) ? 8'h41 : 8'h61) + n - 10);
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_hex(c));
    return c;
  endfunction

  function automatic logic [15:0] high_unit();
    case ($urandom_range(0, 3))
      0:       return 16'hD800;
      1:       return 16'hDBFF;
      default: return 16'(16'hD800 | $urandom_range(0, 'h3FF));
    endcase
  endfunction

  function automatic logic [15:0] low_unit();
    case ($urandom_range(0, 3))
      0:       return 16'hDC00;
      1:       return 16'hDFFF;
      default: return 16'(16'hDC00 | $urandom_range(0, 'h3FF));
    endcase
  endfunction

  task automatic add_byte(input logic [7:0] b);
    src_q.insert(src_q.size(), {1'b0, b});
  endtask

  task automatic add_end();
    src_q.insert(src_q.size(), {1'b1, 8'($urandom_range(0, 255))});
  endtask

  task automatic add_unit(input logic [15:0] v);
    add_byte(BSLASH);
    add_byte(LETTER_U);
    for (int i = 3; i >= 0; i--) add_byte(hex_char(v[i*4 +: 4]));
  endtask

  task automatic add_partial_hex();
    add_byte(BSLASH);
    add_byte(LETTER_U);
    repeat ($urandom_range(0, 3)) add_byte(hex_char(4'($urandom_range(0, 15))));
    add_byte(non_hex());
  endtask

  // one quoted string, mostly well formed, sometimes broken or cut short
  task automatic build_string();
    int         cut;
    int         sel;
    bit         ok;
    logic [7:0] c;
    logic [15:0] v;
    fault_t     flt;
    if ($urandom_range(0, 11) == 0) add_byte(8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 2)) add_byte(WS_CHARS[8*$urandom_range(0, 5) +: 8]);
    add_byte(QUOTE);
    repeat ($urandom_range(0, 8)) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        do c = 8'($urandom_range(8'h20, 8'hFF)); while (c == QUOTE || c == BSLASH);
        add_byte(c);
      end else if (sel < 60) begin
        add_byte(BSLASH);
        add_byte(ESC_CHARS[8*$urandom_range(0, 7) +: 8]);
      end else if (sel < 80) begin
        case ($urandom_range(0, 3))
          0: v = 16'($urandom_range(0, 'h7F));
          1: v = 16'($urandom_range('h80, 'h7FF));
          2: begin
            v = 16'($urandom_range('h800, 'hFFFF));
            if (v >= 16'hD800 && v <= 16'hDFFF) v ^= 16'h2000;
          end
          default: v = BMP_EDGES[16*$urandom_range(0, 5) +: 16];
        endcase
        add_unit(v);
      end else if (sel < 92) begin
        add_unit(high_unit());
        add_unit(low_unit());
      end else begin
        flt = fault_t'($urandom_range(0, 7));
        case (flt)
          FLT_CTRL: add_byte(8'($urandom_range(0, 'h1F)));
          FLT_BAD_ESC: begin
            add_byte(BSLASH);
            do begin
              c  = 8'($urandom_range(0, 255));
              ok = (c != LETTER_U);
              for (int i = 0; i < 8; i++) if (c == ESC_CHARS[8*i +: 8]) ok = 1'b0;
            end while (!ok);
            add_byte(c);
          end
          FLT_BAD_HEX:  add_partial_hex();
          FLT_LONE_LOW: add_unit(low_unit());
          FLT_NO_BSL: begin
            add_unit(high_unit());
            do c = 8'($urandom_range(0, 255)); while (c == BSLASH);
            add_byte(c);
          end
          FLT_NO_U: begin
            add_unit(high_unit());
            add_byte(BSLASH);
            do c = 8'($urandom_range(0, 255)); while (c == LETTER_U);
            add_byte(c);
          end
          FLT_BAD_LOW: begin
            add_unit(high_unit());
            v = 16'($urandom_range(0, 'hFFFF));
            if (v >= 16'hDC00 && v <= 16'hDFFF) v ^= 16'h4000;
            add_unit(v);
          end
          default: begin
            add_unit(high_unit());
            add_partial_hex();
          end
        endcase
      end
    end
    if ($urandom_range(0, 9) != 0) add_byte(QUOTE);
    repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 6) == 0) begin
      cut = $urandom_range(0, src_q.size() - 1);
      while (src_q.size() > cut) src_q.delete(src_q.size() - 1);
    end
    add_end();
  endtask

  task automatic send_item(input logic [8:0] it);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it[7:0];
    in_tlast  <= it[8];
    burst_left--;
    sent_items++;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic flush_src();
    while (src_q.size() > 0) send_item(src_q.pop_front());
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    add_end();
    add_byte(8'h78);
    add_end();
    add_byte(8'h0D);
    add_byte(QUOTE);
    add_byte(8'hFF);
    add_byte(8'h20);
    add_byte(8'h00);
    add_end();
    add_byte(QUOTE);
    add_byte(BSLASH);
    add_end();
    add_byte(QUOTE);
    add_byte(QUOTE);
    add_byte(8'h41);
    add_end();
    add_byte(QUOTE);
    add_byte(BSLASH);
    add_byte(LETTER_U);
    add_byte(8'h46);
    add_byte(8'h66);
    add_byte(8'h46);
    add_byte(8'h66);
    add_end();
    flush_src();

    while (sent_items < ITEM_TARGET) begin
      build_string();
      flush_src();
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
